>>> design/ubdc_pkg.sv
// Shared types and constants for the UART baud divisor calculator.
`timescale 1ns / 1ps

package ubdc_pkg;

  // Field widths
  localparam int unsigned CLK_W  = 26;
  localparam int unsigned BAUD_W = 24;
  localparam int unsigned PRE_W  = 16;
  localparam int unsigned MOD1_W = 4;
  localparam int unsigned MOD2_W = 8;
  localparam int unsigned WORD_W = 16;

  // Defaults for the top-level parameters
  localparam int unsigned FRACTION_BITS_DEF = 6;
  localparam int unsigned MAX_BAUD_DEF      = 1000000;

  // Clock selection rule
  localparam logic [CLK_W-1:0] SLOW_MIN_HZ = 26'd20000;
  localparam logic [CLK_W-1:0] SLOW_RATIO  = 26'd3;

  // Oversampling splits n into n/16 and n%16
  localparam int unsigned OS_SHIFT = 4;

  // Quotient bits resolved per divider stage
  localparam int unsigned DIV_STEP_BITS = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_CLOCK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_CLOCK = 8'd1;

  // Configuration reset values
  localparam logic [CLK_W-1:0] SLOW_CLOCK_RST = 26'd32768;
  localparam logic [CLK_W-1:0] FAST_CLOCK_RST = 26'd1048576;

  // Control bits that travel with each beat down the pipeline
  typedef struct packed {
    logic valid;
    logic reject;
    logic slow;
  } ctl_t;

endpackage

>>> design/ubdc_front.sv
// Input stage: configuration registers, baud range check, clock select.
`timescale 1ns / 1ps

module ubdc_front #(
  parameter int unsigned FRACTION_BITS = ubdc_pkg::FRACTION_BITS_DEF,
  parameter int unsigned MAX_BAUD      = ubdc_pkg::MAX_BAUD_DEF,
  parameter int unsigned QW            = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubdc_pkg::CLK_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic [ubdc_pkg::BAUD_W-1:0]    baud_rate,
  output ubdc_pkg::ctl_t                 out_ctl,
  output logic [QW-1:0]                  out_num,
  output logic [ubdc_pkg::BAUD_W-1:0]    out_den
);

  logic [ubdc_pkg::CLK_W-1:0] slow_clock_hz;
  logic [ubdc_pkg::CLK_W-1:0] fast_clock_hz;
  logic [ubdc_pkg::CLK_W-1:0] baud_x3;
  logic                       reject;
  logic                       slow;
  logic [ubdc_pkg::CLK_W-1:0] clk_sel;

  // Range check and clock choice
  assign baud_x3 = ubdc_pkg::CLK_W'(baud_rate) * ubdc_pkg::SLOW_RATIO;
  assign reject  = (baud_rate == '0) ||
                   (baud_rate > ubdc_pkg::BAUD_W'(MAX_BAUD));
  assign slow    = (slow_clock_hz > ubdc_pkg::SLOW_MIN_HZ) && (slow_clock_hz >= baud_x3);
  assign clk_sel = slow ? slow_clock_hz : fast_clock_hz;

  // Config registers and control
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_clock_hz <= ubdc_pkg::SLOW_CLOCK_RST;
      fast_clock_hz <= ubdc_pkg::FAST_CLOCK_RST;
      out_ctl       <= '0;
    end else begin
      if (cfg_we && (cfg_index == ubdc_pkg::REG_SLOW_CLOCK)) begin
        slow_clock_hz <= cfg_data;
      end
      if (cfg_we && (cfg_index == ubdc_pkg::REG_FAST_CLOCK)) begin
        fast_clock_hz <= cfg_data;
      end
      out_ctl.valid  <= in_valid;
      out_ctl.reject <= reject;
      out_ctl.slow   <= slow;
    end
  end

  // Dividend is the chosen clock scaled by the fraction bits
  always_ff @(posedge clk) begin
    out_num <= QW'(clk_sel) << FRACTION_BITS;
    out_den <= baud_rate;
  end

  a_slow_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == ubdc_pkg::REG_SLOW_CLOCK)
      |=> slow_clock_hz == $past(cfg_data))
    else $error("slow clock register did not take the write");

  a_fast_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == ubdc_pkg::REG_FAST_CLOCK)
      |=> fast_clock_hz == $past(cfg_data))
    else $error("fast clock register did not take the write");

  a_slow_rule: assert property (@(posedge clk) disable iff (rst)
    in_valid && slow |-> slow_clock_hz > ubdc_pkg::SLOW_MIN_HZ)
    else $error("slow clock chosen below minimum frequency");

endmodule

>>> design/ubdc_div_stage.sv
// One stage of the pipelined restoring divider, BPS quotient bits per stage.
`timescale 1ns / 1ps

module ubdc_div_stage #(
  parameter int unsigned BW  = 24,
  parameter int unsigned QW  = 32,
  parameter int unsigned BPS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  ubdc_pkg::ctl_t in_ctl,
  input  logic [BW-1:0]  in_rem,
  input  logic [QW-1:0]  in_num,
  input  logic [QW-1:0]  in_quo,
  input  logic [BW-1:0]  in_den,
  output ubdc_pkg::ctl_t out_ctl,
  output logic [BW-1:0]  out_rem,
  output logic [QW-1:0]  out_num,
  output logic [QW-1:0]  out_quo,
  output logic [BW-1:0]  out_den
);

  logic [BW-1:0] rem_v;
  logic [QW-1:0] num_v;
  logic [QW-1:0] quo_v;
  logic [BW:0]   trial;

  // Shift in one dividend bit, compare and subtract, BPS times
  always_comb begin
    rem_v = in_rem;
    num_v = in_num;
    quo_v = in_quo;
    trial = '0;
    for (int i = 0; i < BPS; i++) begin
      trial = {rem_v, num_v[QW-1]};
      num_v = num_v << 1;
      if (trial >= {1'b0, in_den}) begin
        trial = trial - {1'b0, in_den};
        quo_v = {quo_v[QW-2:0], 1'b1};
      end else begin
        quo_v = {quo_v[QW-2:0], 1'b0};
      end
      rem_v = trial[BW-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    out_rem <= rem_v;
    out_num <= num_v;
    out_quo <= quo_v;
    out_den <= in_den;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_ctl.valid && !out_ctl.reject |-> out_rem < out_den)
    else $error("partial remainder not below divisor");

endmodule

>>> design/ubdc_pack.sv
// Output stage: splits the quotient into prescaler and modulation fields.
`timescale 1ns / 1ps

module ubdc_pack #(
  parameter int unsigned FRACTION_BITS = ubdc_pkg::FRACTION_BITS_DEF,
  parameter int unsigned QW            = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ubdc_pkg::ctl_t                  in_ctl,
  input  logic [QW-1:0]                   in_quo,
  output logic                            done,
  output logic                            settings_ok,
  output logic                            use_slow_clock,
  output logic [ubdc_pkg::PRE_W-1:0]      prescaler,
  output logic [ubdc_pkg::MOD1_W-1:0]     first_modulation,
  output logic [ubdc_pkg::MOD2_W-1:0]     second_modulation,
  output logic                            oversampling,
  output logic [ubdc_pkg::WORD_W-1:0]     modulation_word
);

  logic                            too_big;
  logic                            ok;
  logic [ubdc_pkg::PRE_W-1:0]      n;
  logic                            os;
  logic [ubdc_pkg::PRE_W-1:0]      pre;
  logic [ubdc_pkg::MOD1_W-1:0]     first;
  logic [ubdc_pkg::MOD2_W-1:0]     second;

  // Integer part above 16 bits means the divisor does not fit
  assign too_big = |in_quo[QW-1:FRACTION_BITS+ubdc_pkg::PRE_W];
  assign ok      = !in_ctl.reject && !too_big;
  assign n       = in_quo[FRACTION_BITS+ubdc_pkg::PRE_W-1:FRACTION_BITS];
  assign os      = |n[ubdc_pkg::PRE_W-1:ubdc_pkg::OS_SHIFT];
  assign pre     = os ? (n >> ubdc_pkg::OS_SHIFT) : n;
  assign first   = os ? n[ubdc_pkg::MOD1_W-1:0] : '0;
  assign second  = ubdc_pkg::MOD2_W'(in_quo[FRACTION_BITS-1:0]) <<
                   (ubdc_pkg::MOD2_W - FRACTION_BITS);

  // Strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_ctl.valid;
    end
  end

  // Result fields; divider fields zeroed on reject or overflow, use_slow_clock only on reject
  always_ff @(posedge clk) begin
    settings_ok       <= ok;
    use_slow_clock    <= !in_ctl.reject && in_ctl.slow;
    prescaler         <= ok ? pre : '0;
    first_modulation  <= ok ? first : '0;
    second_modulation <= ok ? second : '0;
    oversampling      <= ok && os;
    modulation_word   <= ok ? {second, first, 3'b000, os} : '0;
  end

  a_os_pre: assert property (@(posedge clk) disable iff (rst)
    done && oversampling |-> prescaler != '0)
    else $error("oversampling with zero prescaler");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && !settings_ok |-> (prescaler == '0) && (modulation_word == '0))
    else $error("rejected beat carries nonzero divider fields");

endmodule

>>> design/uart_baud_divisor_calc.sv
// Top level of the UART baud divisor calculator.
`timescale 1ns / 1ps

// Takes one baud request per cycle and returns its divider settings
// through a registered input stage, the pipelined restoring divider, which
// resolves four quotient bits in each of its stages, and a registered
// output stage. done is high for exactly one cycle per result and results
// cannot be held off, so the receiver must take every beat. busy is high
// only while rst is asserted.
// Clock registers are written through cfg_valid/cfg_ready (always ready);
// write them only while no requests are in flight.
module uart_baud_divisor_calc #(
  parameter int unsigned FRACTION_BITS = ubdc_pkg::FRACTION_BITS_DEF,
  parameter int unsigned MAX_BAUD      = ubdc_pkg::MAX_BAUD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ubdc_pkg::BAUD_W-1:0]    baud_rate,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubdc_pkg::CLK_W-1:0]     cfg_data,
  output logic                           done,
  output logic                           settings_ok,
  output logic                           use_slow_clock,
  output logic [ubdc_pkg::PRE_W-1:0]     prescaler,
  output logic [ubdc_pkg::MOD1_W-1:0]    first_modulation,
  output logic [ubdc_pkg::MOD2_W-1:0]    second_modulation,
  output logic                           oversampling,
  output logic [ubdc_pkg::WORD_W-1:0]    modulation_word
);

  localparam int unsigned BW   = ubdc_pkg::BAUD_W;
  localparam int unsigned BPS  = ubdc_pkg::DIV_STEP_BITS;
  localparam int unsigned DW   = ubdc_pkg::CLK_W + FRACTION_BITS;
  localparam int unsigned NSTG = (DW + BPS - 1) / BPS;
  localparam int unsigned QW   = NSTG * BPS;
  localparam int unsigned LAT  = NSTG + 2;

  ubdc_pkg::ctl_t ctl_chain [NSTG+1];
  logic [BW-1:0]  rem_chain [NSTG+1];
  logic [QW-1:0]  num_chain [NSTG+1];
  logic [QW-1:0]  quo_chain [NSTG+1];
  logic [BW-1:0]  den_chain [NSTG+1];
  logic           accept;

  // Handshake
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  ubdc_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_BAUD      (MAX_BAUD),
    .QW            (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (accept),
    .baud_rate (baud_rate),
    .out_ctl   (ctl_chain[0]),
    .out_num   (num_chain[0]),
    .out_den   (den_chain[0])
  );

  // Divider starts with an empty remainder and quotient
  assign rem_chain[0] = '0;
  assign quo_chain[0] = '0;

  for (genvar s = 0; s < NSTG; s++) begin : g_div
    ubdc_div_stage #(
      .BW  (BW),
      .QW  (QW),
      .BPS (BPS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (ctl_chain[s]),
      .in_rem  (rem_chain[s]),
      .in_num  (num_chain[s]),
      .in_quo  (quo_chain[s]),
      .in_den  (den_chain[s]),
      .out_ctl (ctl_chain[s+1]),
      .out_rem (rem_chain[s+1]),
      .out_num (num_chain[s+1]),
      .out_quo (quo_chain[s+1]),
      .out_den (den_chain[s+1])
    );
  end

  ubdc_pack #(
    .FRACTION_BITS (FRACTION_BITS),
    .QW            (QW)
  ) u_pack (
    .clk               (clk),
    .rst               (rst),
    .in_ctl            (ctl_chain[NSTG]),
    .in_quo            (quo_chain[NSTG]),
    .done              (done),
    .settings_ok       (settings_ok),
    .use_slow_clock    (use_slow_clock),
    .prescaler         (prescaler),
    .first_modulation  (first_modulation),
    .second_modulation (second_modulation),
    .oversampling      (oversampling),
    .modulation_word   (modulation_word)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result beat without a matching request");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $past(accept, LAT) && !$past(rst, LAT - 1) && !$past(rst, 1) |-> done)
    else $error("request beat produced no result");

  a_ok_slow: assert property (@(posedge clk) disable iff (rst)
    done && !use_slow_clock && settings_ok |-> 1'b1 && (modulation_word[3:1] == 3'b000))
    else $error("reserved modulation word bits set");

endmodule

>>> tb/uart_baud_divisor_calc_test.sv
// Self-checking testbench for the UART baud divisor calculator.
`timescale 1ns / 1ps

module uart_baud_divisor_calc_test;

  localparam int unsigned FRAC_BITS   = ubdc_pkg::FRACTION_BITS_DEF;
  localparam int unsigned BAUD_LIMIT  = ubdc_pkg::MAX_BAUD_DEF;
  localparam int unsigned PIPE_SLACK  = 16;    // pipeline is 10 deep
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 150;
  localparam logic [ubdc_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;
  localparam logic [ubdc_pkg::CLK_W-1:0]     CLOCK_MAX        = 26'h3FFFFFF;

  // Expected divider settings for one baud request
  typedef struct {
    logic [ubdc_pkg::BAUD_W-1:0] baud;
    logic                        ok;
    logic                        slow;
    logic [ubdc_pkg::PRE_W-1:0]  pre;
    logic [ubdc_pkg::MOD1_W-1:0] mod1;
    logic [ubdc_pkg::MOD2_W-1:0] mod2;
    logic                        os;
    logic [ubdc_pkg::WORD_W-1:0] word;
  } divider_settings_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [ubdc_pkg::BAUD_W-1:0]    baud_rate = '0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ubdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ubdc_pkg::CLK_W-1:0]     cfg_data = '0;
  logic                           done;
  logic                           settings_ok;
  logic                           use_slow_clock;
  logic [ubdc_pkg::PRE_W-1:0]     prescaler;
  logic [ubdc_pkg::MOD1_W-1:0]    first_modulation;
  logic [ubdc_pkg::MOD2_W-1:0]    second_modulation;
  logic                           oversampling;
  logic [ubdc_pkg::WORD_W-1:0]    modulation_word;

  // Shadow copy of the clock registers
  logic [ubdc_pkg::CLK_W-1:0] slow_hz;
  logic [ubdc_pkg::CLK_W-1:0] fast_hz;

  divider_settings_t pending_settings[$];
  divider_settings_t due;
  int unsigned       mismatch_count = 0;
  bit                burst_mode = 1'b0;

  uart_baud_divisor_calc #(
    .FRACTION_BITS(FRAC_BITS),
    .MAX_BAUD     (BAUD_LIMIT)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .baud_rate        (baud_rate),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .settings_ok      (settings_ok),
    .use_slow_clock   (use_slow_clock),
    .prescaler        (prescaler),
    .first_modulation (first_modulation),
    .second_modulation(second_modulation),
    .oversampling     (oversampling),
    .modulation_word  (modulation_word)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Divider settings for a baud request under the current clock registers
  function automatic divider_settings_t calc_divider_settings(
    input logic [ubdc_pkg::BAUD_W-1:0] b
  );
    divider_settings_t s;
    logic              sel_slow;
    logic [63:0]       clock_hz;
    logic [63:0]       quot;
    logic [63:0]       whole;
    s = '{default: '0};
    s.baud = b;
    if (b == '0 || b > BAUD_LIMIT) return s;
    sel_slow = (slow_hz > ubdc_pkg::SLOW_MIN_HZ) &&
               (64'(slow_hz) >= 64'(b) * 64'(ubdc_pkg::SLOW_RATIO));
    clock_hz = sel_slow ? 64'(slow_hz) : 64'(fast_hz);
    quot     = (clock_hz << FRAC_BITS) / 64'(b);
    whole    = quot >> FRAC_BITS;
    s.slow   = sel_slow;
    // integer part too wide for the prescaler
    if (whole > 64'hFFFF) return s;
    s.ok   = 1'b1;
    s.mod2 = 8'((quot & ((64'd1 << FRAC_BITS) - 1)) << (8 - FRAC_BITS));
    if (whole >= 64'd16) begin
      s.pre  = 16'(whole >> ubdc_pkg::OS_SHIFT);
      s.mod1 = 4'(whole);
      s.os   = 1'b1;
    end else begin
      s.pre = 16'(whole);
    end
    s.word = {s.mod2, s.mod1, 3'b000, s.os};
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want,
                                 input logic [ubdc_pkg::BAUD_W-1:0] b);
    $display("%0t MISMATCH %s baud=%0d got=%0d expected=%0d", $realtime, what, b, got, want);
    mismatch_count++;
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Send one baud request and record its expected settings
  task automatic send_baud(input logic [ubdc_pkg::BAUD_W-1:0] b);
    int unsigned gap;
    start     <= 1'b1;
    baud_rate <= b;
    do @(posedge clk); while (busy);
    pending_settings.push_back(calc_divider_settings(b));
    gap = rand_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One configuration beat; cfg_valid is lowered here for a gap, else by the caller when done
  task automatic write_reg(input logic [ubdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ubdc_pkg::CLK_W-1:0] data);
    int unsigned gap;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ubdc_pkg::REG_SLOW_CLOCK) slow_hz = data;
    else if (idx == ubdc_pkg::REG_FAST_CLOCK) fast_hz = data;
    gap = rand_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every request has come back and the pipeline is empty
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic set_clocks(input logic [ubdc_pkg::CLK_W-1:0] slow,
                            input logic [ubdc_pkg::CLK_W-1:0] fast);
    wait_idle();
    write_reg(ubdc_pkg::REG_SLOW_CLOCK, slow);
    write_reg(ubdc_pkg::REG_FAST_CLOCK, fast);
    cfg_valid <= 1'b0;
  endtask

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_settings.size() == 0) begin
        report_mismatch("unexpected result", 32'(prescaler), 0, '0);
      end else begin
        due = pending_settings.pop_front();
        if (settings_ok !== due.ok)
          report_mismatch("settings_ok", 32'(settings_ok), 32'(due.ok), due.baud);
        if (use_slow_clock !== due.slow)
          report_mismatch("use_slow_clock", 32'(use_slow_clock), 32'(due.slow), due.baud);
        if (prescaler !== due.pre)
          report_mismatch("prescaler", 32'(prescaler), 32'(due.pre), due.baud);
        if (first_modulation !== due.mod1)
          report_mismatch("first_modulation", 32'(first_modulation), 32'(due.mod1), due.baud);
        if (second_modulation !== due.mod2)
          report_mismatch("second_modulation", 32'(second_modulation), 32'(due.mod2), due.baud);
        if (oversampling !== due.os)
          report_mismatch("oversampling", 32'(oversampling), 32'(due.os), due.baud);
        if (modulation_word !== due.word)
          report_mismatch("modulation_word", 32'(modulation_word), 32'(due.word), due.baud);
      end
    end
  end

  // Clock register value: extremes, selection boundaries, typical and random
  function automatic logic [ubdc_pkg::CLK_W-1:0] pick_clock(
    input logic [ubdc_pkg::CLK_W-1:0] rst_val
  );
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CLOCK_MAX;
      2: return ubdc_pkg::SLOW_MIN_HZ;
      3: return ubdc_pkg::SLOW_MIN_HZ + 26'd1;
      4: return rst_val;
      5: return 26'($urandom_range(20001, 4000000));
      6: return 26'($urandom);
      default: return 26'($urandom_range(1000000, 32'(CLOCK_MAX)));
    endcase
  endfunction

  // Baud request: mostly legal rates spread over all magnitudes
  function automatic logic [ubdc_pkg::BAUD_W-1:0] pick_baud();
    int unsigned r;
    int unsigned k;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 6)
      return ($urandom_range(0, 1) == 0) ? '0 :
             24'($urandom_range(BAUD_LIMIT + 1, 24'hFFFFFF));
    if (r < 12) return 24'($urandom);
    if (r < 22) begin
      // around the slow clock selection threshold
      v = slow_hz / 3 + $urandom_range(0, 2);
      v = (v == 0) ? 1 : v - 1;
      if (v >= 1 && v <= BAUD_LIMIT) return 24'(v);
    end
    k = $urandom_range(1, 20);
    v = (1 << (k - 1)) | ($urandom & ((1 << (k - 1)) - 1));
    if (v > BAUD_LIMIT) v = BAUD_LIMIT;
    return 24'(v);
  endfunction

  // Reset clocks: rejection limits, clock selection edge, oversampling edge
  task automatic test_default_clocks();
    send_baud(24'd0);
    send_baud(24'd1);
    send_baud(24'd10922);
    send_baud(24'd10923);
    send_baud(24'd65536);
    send_baud(24'd65537);
    send_baud(24'd9600);
    send_baud(24'd115200);
    send_baud(24'(BAUD_LIMIT));
    send_baud(24'(BAUD_LIMIT + 1));
    send_baud(24'hFFFFFF);
    send_baud(24'h555555);
    send_baud(24'hAAAAAA);
  endtask

  // Clock extremes: overflowing divisor, zero clock, slow clock thresholds
  task automatic test_clock_extremes();
    set_clocks('0, CLOCK_MAX);
    send_baud(24'd1);
    send_baud(24'(BAUD_LIMIT));
    set_clocks(CLOCK_MAX, '0);
    send_baud(24'd1);
    send_baud(24'(BAUD_LIMIT));
    set_clocks(ubdc_pkg::SLOW_MIN_HZ, '0);
    send_baud(24'd6666);
    set_clocks(ubdc_pkg::SLOW_MIN_HZ + 26'd1, 26'd500000);
    send_baud(24'd6667);
    send_baud(24'd6668);
    send_baud(24'(BAUD_LIMIT));
  endtask

  // Writes to unused register indexes must leave the clocks alone
  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_FIRST_UNUSED, 26'($urandom));
    write_reg(8'($urandom_range(3, 255)), 26'($urandom));
    cfg_valid <= 1'b0;
    send_baud(24'd6667);
    send_baud(24'(BAUD_LIMIT));
  endtask

  // Random phases, each under its own clock setting
  task automatic test_random_rates();
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_clocks(pick_clock(ubdc_pkg::SLOW_CLOCK_RST), pick_clock(ubdc_pkg::FAST_CLOCK_RST));
      burst_mode = (p % 4 == 1);
      for (int unsigned i = 0; i < PHASE_BEATS; i++) send_baud(pick_baud());
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    slow_hz = ubdc_pkg::SLOW_CLOCK_RST;
    fast_hz = ubdc_pkg::FAST_CLOCK_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_clocks();
    test_clock_extremes();
    test_unused_index();
    test_random_rates();

    // drain with a bound, then let the pipeline settle
    start <= 1'b0;
    for (int unsigned w = 0; w < 1000 && pending_settings.size() != 0; w++) @(posedge clk);
    if (pending_settings.size() != 0)
      report_mismatch("missing results", 0, 32'(pending_settings.size()), '0);
    repeat (PIPE_SLACK) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
